### sv/prefix_permission_table_defines.svh
// Assertion macros shared by the permission table RTL.
// Depends on nothing; the including module supplies clock and reset.
`ifndef PREFIX_PERMISSION_TABLE_DEFINES_SVH
`define PREFIX_PERMISSION_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPT_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("permission table check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("permission table check failed");

`endif

### sv/ppt_pkg.sv
// Types and constants of the prefix permission table.
// Used by ppt_cell, prefix_permission_table and the testbench; depends on nothing.
package ppt_pkg;

   // Request kind carried on the input tuser.
   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_CHECK  = 1'b1
   } ppt_req_type;

   // Longest prefix that an IPv6 address has.
   localparam logic [7:0] FULL_PREFIX = 8'd128;

   // A request as it moves down the row of cells.
   typedef struct packed {
      ppt_req_type op;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  plen;
      logic [7:0]  perm;
      logic        granted;
      logic        rejected;
   } ppt_token_type;

endpackage

### sv/ppt_cell.sv
// One table entry of the prefix permission table and its compare stage.
// Depends on ppt_pkg.
module ppt_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CNT_W-1:0]      count,     // Entries in use, stable while a request is in flight.
   input  logic                  up_valid,
   input  ppt_pkg::ppt_token_type up_tok,
   output logic                  dn_valid,
   output ppt_pkg::ppt_token_type dn_tok
);

   logic                   tok_valid_ff;
   ppt_pkg::ppt_token_type tok_ff;
   ppt_pkg::ppt_token_type tok_in;
   logic [63:0]            entry_hi_ff, entry_hi_in;
   logic [63:0]            entry_lo_ff, entry_lo_in;
   logic [7:0]             entry_prefix_ff, entry_prefix_in;
   logic [7:0]             entry_perms_ff, entry_perms_in;
   logic [127:0]           net_mask;
   logic                   occupied;
   logic                   hit;
   logic                   store;

   // The leading prefix bits of the stored address, most significant first.
   always_comb begin
      for (int j = 0; j < 128; j++) begin
         net_mask[127-j] = (8'(j) < entry_prefix_ff);
      end
   end

   assign occupied = (CNT_W'(INDEX) < count);

   // A check hits when the network part agrees and a permission bit is shared.
   assign hit = up_valid && (up_tok.op == ppt_pkg::REQ_CHECK) && occupied &&
                ((({up_tok.addr_hi, up_tok.addr_lo} ^ {entry_hi_ff, entry_lo_ff}) &
                  net_mask) == 128'd0) &&
                ((entry_perms_ff & up_tok.perm) != 8'd0);

   // An insert lands in the first free entry.
   assign store = up_valid && (up_tok.op == ppt_pkg::REQ_INSERT) && !up_tok.rejected &&
                  (count == CNT_W'(INDEX));

   always_comb begin
      entry_hi_in     = entry_hi_ff;
      entry_lo_in     = entry_lo_ff;
      entry_prefix_in = entry_prefix_ff;
      entry_perms_in  = entry_perms_ff;
      if (store) begin
         entry_hi_in     = up_tok.addr_hi;
         entry_lo_in     = up_tok.addr_lo;
         entry_prefix_in = up_tok.plen;
         entry_perms_in  = up_tok.perm;
      end
   end

   // The transaction moves on to the next cell with the hit folded in.
   always_comb begin
      tok_in         = up_tok;
      tok_in.granted = up_tok.granted | hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff          <= tok_in;
      entry_hi_ff     <= entry_hi_in;
      entry_lo_ff     <= entry_lo_in;
      entry_prefix_ff <= entry_prefix_in;
      entry_perms_ff  <= entry_perms_in;
   end

   assign dn_valid = tok_valid_ff;
   assign dn_tok   = tok_ff;

endmodule

### sv/prefix_permission_table.sv
// Top level of the IPv6 prefix permission table: a row of entry cells.
// Depends on ppt_pkg, ppt_cell and prefix_permission_table_defines.svh.
//
//   Port group   Direction   Carries
//   req_*        in          insert or check transaction (tuser: request kind)
//   rsp_*        out         granted and rejected result
//
// Each transaction walks the row of TABLE_DEPTH cells, one cell per cycle, and its
// result then waits in the output register until it is taken.
// One transaction is in the table at a time; the next is accepted in the cycle after
// the result is taken.
// Reset empties the table at once; entry contents are not cleared.
// A stalled result holds its value and keeps req_tready low.
`include "prefix_permission_table_defines.svh"

module prefix_permission_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,   // addr_hi[63:0], addr_lo[127:64],
                                      // prefix_len[135:128], perm_mask[143:136]
   input  logic          req_tuser,   // req_type[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata    // granted[0], rejected[1], zero[7:2]
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic                   busy_ff, busy_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_data_ff, rsp_data_in;
   logic                   req_fire;
   logic                   rsp_fire;
   logic                   full;
   logic [7:0]             plen_clamped;
   ppt_pkg::ppt_token_type new_tok;
   logic                   chain_valid [0:TABLE_DEPTH];
   ppt_pkg::ppt_token_type chain_tok   [0:TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_busy;
   logic                   done;
   ppt_pkg::ppt_token_type done_tok;

   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign full       = (count_ff == CNT_W'(TABLE_DEPTH));

   // Build the transaction that enters the first cell.
   assign plen_clamped = (req_tdata[135:128] > ppt_pkg::FULL_PREFIX) ?
                         ppt_pkg::FULL_PREFIX : req_tdata[135:128];

   always_comb begin
      new_tok.op       = ppt_pkg::ppt_req_type'(req_tuser);
      new_tok.addr_hi  = req_tdata[63:0];
      new_tok.addr_lo  = req_tdata[127:64];
      new_tok.plen     = plen_clamped;
      new_tok.perm     = req_tdata[143:136];
      new_tok.granted  = 1'b0;
      new_tok.rejected = (ppt_pkg::ppt_req_type'(req_tuser) == ppt_pkg::REQ_INSERT) && full;
   end

   assign chain_valid[0] = req_fire;
   assign chain_tok[0]   = new_tok;

   // The row of entry cells.
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      ppt_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .count    (count_ff),
         .up_valid (chain_valid[g]),
         .up_tok   (chain_tok[g]),
         .dn_valid (chain_valid[g+1]),
         .dn_tok   (chain_tok[g+1])
      );
      assign cell_busy[g] = chain_valid[g+1];
   end

   assign done     = chain_valid[TABLE_DEPTH];
   assign done_tok = chain_tok[TABLE_DEPTH];

   // The fill count grows once a successful insert leaves the row.
   always_comb begin
      count_in = count_ff;
      if (done && (done_tok.op == ppt_pkg::REQ_INSERT) && !done_tok.rejected) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Output register and the busy flag that spans acceptance to delivery.
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_fire) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {done_tok.rejected,
                         done_tok.granted && (done_tok.op == ppt_pkg::REQ_CHECK)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   // The table never holds more entries than it has cells.
   `PPT_ASSERT_NOW(a_count_max, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   // A new transaction enters only an empty row.
   `PPT_ASSERT_NOW(a_row_empty, req_fire, cell_busy == '0)
   // A result is only shown for an accepted transaction.
   `PPT_ASSERT_NOW(a_rsp_busy, rsp_valid_ff, busy_ff)
   // A result never both grants and rejects.
   `PPT_ASSERT_NOW(a_rsp_excl, rsp_valid_ff, !(rsp_data_ff[0] && rsp_data_ff[1]))
   // At most one transaction is inside the row.
   `PPT_ASSERT_NOW(a_one_tok, 1'b1, $onehot0(cell_busy))
   // A full table stays full while no transaction leaves the row.
   `PPT_ASSERT_NEXT(a_full_hold, full && !done, count_ff == CNT_W'(TABLE_DEPTH))

endmodule

### tb/prefix_permission_table_checker.sv
// Scoreboard for the prefix permission table: predicts each result from the accepted requests.
// Depends on ppt_pkg; instantiated by prefix_permission_table_tb next to the table.
module prefix_permission_table_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,   // addr_hi[63:0], addr_lo[127:64],
                                     // prefix_len[135:128], perm_mask[143:136]
   input  logic         req_tuser,   // req_type[0]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,   // granted[0], rejected[1], zero[7:2]
   output int           fail_count,
   output int           pending_results,
   output int           check_count,
   output int           grant_count,
   output int           insert_count,
   output int           reject_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // One stored access rule, with the prefix length already clamped.
   typedef struct {
      logic [127:0] addr;
      logic [7:0]   plen;
      logic [7:0]   perm;
   } acl_rule_type;

   // The answer that one request must produce.
   typedef struct packed {
      ppt_pkg::ppt_req_type op;
      logic                 granted;
      logic                 rejected;
   } table_verdict_type;

   acl_rule_type      acl_rules[TABLE_DEPTH];
   int unsigned       acl_count;
   table_verdict_type expected_verdicts[$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      check_count     = 0;
      grant_count     = 0;
      insert_count    = 0;
      reject_count    = 0;
      acl_count       = 0;
   end

   // Apply each accepted request to the rule list, then score each accepted result.
   always @(posedge clock) begin : predict_and_score
      table_verdict_type verdict;
      table_verdict_type oldest;
      logic [127:0]      req_addr;
      logic [127:0]      keep;
      logic [7:0]        req_plen;
      logic [7:0]        req_perm;
      logic              got_granted;
      logic              got_rejected;

      if (reset) begin
         acl_count = 0;
         expected_verdicts.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            req_addr = {req_tdata[63:0], req_tdata[127:64]};
            req_plen = req_tdata[135:128];
            req_perm = req_tdata[143:136];
            verdict  = '{op: ppt_pkg::ppt_req_type'(req_tuser), granted: 1'b0,
                         rejected: 1'b0};
            if (verdict.op == ppt_pkg::REQ_INSERT) begin
               if (acl_count >= TABLE_DEPTH) begin
                  verdict.rejected = 1'b1;
               end else begin
                  acl_rules[acl_count].addr = req_addr;
                  acl_rules[acl_count].plen = (req_plen > ppt_pkg::FULL_PREFIX) ?
                                              ppt_pkg::FULL_PREFIX : req_plen;
                  acl_rules[acl_count].perm = req_perm;
                  acl_count++;
               end
            end else begin
               // Any rule whose network covers the address and shares a permission grants.
               for (int i = 0; i < acl_count; i++) begin
                  keep = (acl_rules[i].plen == 0) ? '0 : ~128'd0 << (128 - acl_rules[i].plen);
                  if ((((req_addr ^ acl_rules[i].addr) & keep) == '0) &&
                      ((acl_rules[i].perm & req_perm) != 8'd0)) begin
                     verdict.granted = 1'b1;
                  end
               end
            end
            expected_verdicts.push_back(verdict);
         end

         if (rsp_tvalid && rsp_tready) begin
            got_granted  = rsp_tdata[0];
            got_rejected = rsp_tdata[1];
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected result transaction granted=%0b rejected=%0b",
                        $time, got_granted, got_rejected);
               fail_count++;
            end else begin
               oldest = expected_verdicts.pop_front();
               if (oldest.granted !== got_granted || oldest.rejected !== got_rejected) begin
                  $display({"%0t: %s result mismatch: expected granted=%0b rejected=%0b, ",
                            "got granted=%0b rejected=%0b"},
                           $time, oldest.op.name(), oldest.granted, oldest.rejected,
                           got_granted, got_rejected);
                  fail_count++;
               end
               if (oldest.op == ppt_pkg::REQ_CHECK) begin
                  check_count++;
                  grant_count += oldest.granted;
               end else begin
                  insert_count++;
                  reject_count += oldest.rejected;
               end
            end
         end
      end
      pending_results = expected_verdicts.size();
   end

endmodule

### tb/prefix_permission_table_tb.sv
// Top of the prefix permission table testbench: clock, reset, request and result traffic.
// Depends on ppt_pkg, prefix_permission_table and prefix_permission_table_checker.
module prefix_permission_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 580;
   localparam int CALM_ITEMS   = 100;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;   // addr_hi[63:0], addr_lo[127:64],
                                   // prefix_len[135:128], perm_mask[143:136]
   logic         req_tuser = 1'b0; // req_type[0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;        // granted[0], rejected[1], zero[7:2]

   int fail_count;
   int pending_results;
   int check_count;
   int grant_count;
   int insert_count;
   int reject_count;

   // Random idling is switched off for the closing stretch of the run.
   bit idle_enable = 1'b1;
   int stall_left  = 0;

   // Networks that the table holds, kept to aim checks near stored prefixes.
   logic [127:0] known_addr[$];
   logic [7:0]   known_plen[$];
   logic [7:0]   known_perm[$];

   prefix_permission_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   prefix_permission_table_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .check_count     (check_count),
      .grant_count     (grant_count),
      .insert_count    (insert_count),
      .reject_count    (reject_count)
   );

   always #1 clock = ~clock;

   // Result side backpressure: random stall bursts, always ready in the calm stretch.
   always @(posedge clock) begin
      if (!idle_enable) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one request, possibly after an idle burst, and wait until it is taken.
   task automatic send_request(input ppt_pkg::ppt_req_type kind, input logic [127:0] addr,
                               input logic [7:0] plen, input logic [7:0] perm);
      int gap;
      if (idle_enable && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {perm, plen, addr[63:0], addr[127:64]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == ppt_pkg::REQ_INSERT && known_addr.size() < TABLE_DEPTH) begin
         known_addr.push_back(addr);
         known_plen.push_back((plen > ppt_pkg::FULL_PREFIX) ? ppt_pkg::FULL_PREFIX : plen);
         known_perm.push_back(perm);
      end
   endtask

   // Stimulus: directed corner cases, then mostly checks aimed at stored networks.
   initial begin : stimulus
      logic [127:0] addr;
      logic [127:0] keep;
      logic [127:0] noise;
      logic [7:0]   plen;
      logic [7:0]   perm;
      int unsigned  pick;
      int unsigned  roll;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // An empty table grants nothing, whatever is asked.
      send_request(ppt_pkg::REQ_CHECK, ~128'd0, 8'd0, 8'hff);
      send_request(ppt_pkg::REQ_CHECK, '0, 8'd200, 8'hff);
      // A zero-length prefix covers every address; its only permission is the top bit.
      send_request(ppt_pkg::REQ_INSERT, 128'h20010db8_00000000_00000000_00000000, 8'd0, 8'h80);
      send_request(ppt_pkg::REQ_CHECK, 128'h3ffe0000_12345678_9abcdef0_0f0f0f0f, 8'd0, 8'h80);
      send_request(ppt_pkg::REQ_CHECK, 128'h3ffe0000_12345678_9abcdef0_0f0f0f0f, 8'd0, 8'h7f);
      send_request(ppt_pkg::REQ_CHECK, 128'h3ffe0000_12345678_9abcdef0_0f0f0f0f, 8'd0, 8'h00);
      // An overlong prefix is clamped to a full-address match.
      send_request(ppt_pkg::REQ_INSERT, ~128'd0, 8'd255, 8'h01);
      send_request(ppt_pkg::REQ_CHECK, ~128'd0, 8'd0, 8'h01);
      send_request(ppt_pkg::REQ_CHECK, ~128'd1, 8'd0, 8'h01);
      // A /64 network ignores the interface half of the address.
      send_request(ppt_pkg::REQ_INSERT, 128'h20010db8_00000000_deadbeef_00000001, 8'd64, 8'h02);
      send_request(ppt_pkg::REQ_CHECK, 128'h20010db8_00000000_01234567_89abcdef, 8'd128, 8'h02);
      send_request(ppt_pkg::REQ_CHECK, 128'h20010db8_00000001_deadbeef_00000001, 8'd64, 8'h02);
      // A one-bit prefix splits the address space in half.
      send_request(ppt_pkg::REQ_INSERT, 128'h80000000_00000000_00000000_00000000, 8'd1, 8'h04);
      send_request(ppt_pkg::REQ_CHECK, 128'h81234567_89abcdef_fedcba98_76543210, 8'd0, 8'h04);
      send_request(ppt_pkg::REQ_CHECK, 128'h7fffffff_ffffffff_ffffffff_ffffffff, 8'd0, 8'h04);
      // A host route at the all-zero address.
      send_request(ppt_pkg::REQ_INSERT, '0, 8'd128, 8'h08);
      send_request(ppt_pkg::REQ_CHECK, '0, 8'd0, 8'h08);
      send_request(ppt_pkg::REQ_CHECK, 128'd1, 8'd0, 8'h08);
      // Prefix lengths on either side of the half-address and full-address boundaries.
      send_request(ppt_pkg::REQ_INSERT, 128'hfe800000_00000000_02005eff_fe000001, 8'd127, 8'h10);
      send_request(ppt_pkg::REQ_INSERT, 128'h20020a00_00010000_80000000_00000000, 8'd65, 8'h20);
      send_request(ppt_pkg::REQ_INSERT, 128'hfd123456_789abcde_00000000_00000000, 8'd63, 8'h40);
      send_request(ppt_pkg::REQ_INSERT, 128'h0a0b0c0d_0e0f1011_12131415_16171819, 8'd129, 8'hff);

      // Random traffic until the table fills, then refused inserts keep coming.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) idle_enable = 1'b0;
         noise = {$urandom, $urandom, $urandom, $urandom};
         roll  = $urandom_range(0, 99);
         if (roll < 12) begin
            plen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(129, 255)) :
                                                 8'($urandom_range(0, 128));
            perm = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
                                                 8'($urandom_range(1, 127));
            send_request(ppt_pkg::REQ_INSERT, noise, plen, perm);
         end else if (roll < 22) begin
            send_request(ppt_pkg::REQ_CHECK, {$urandom, $urandom, $urandom, $urandom},
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            // Start from a stored network, then keep it, break it inside the prefix,
            // or scramble only the host bits.
            pick = $urandom_range(0, known_addr.size() - 1);
            addr = known_addr[pick];
            plen = known_plen[pick];
            keep = (plen == 0) ? '0 : ~128'd0 << (128 - plen);
            roll = $urandom_range(0, 2);
            if (roll == 1 && plen != 0) begin
               addr ^= 128'd1 << (128 - $urandom_range(1, plen));
            end else if (roll == 2) begin
               addr = (addr & keep) | (noise & ~keep);
            end
            case ($urandom_range(0, 3))
               0: perm = 8'd1 << $urandom_range(0, 6);
               1: perm = known_perm[pick];
               2: perm = ~known_perm[pick];
               default: perm = 8'($urandom_range(0, 255));
            endcase
            send_request(ppt_pkg::REQ_CHECK, addr, 8'($urandom_range(0, 255)), perm);
         end
      end
      req_tvalid <= 1'b0;

      // Drain the table, then allow one more walk down the row of cells.
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 4) @(posedge clock);

      $display("Covered %0d checks (%0d granted) and %0d inserts (%0d refused on a full table).",
               check_count, grant_count, insert_count, reject_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      #500000;
      $display("tb: failure");
      $finish;
   end

endmodule
